>>> sv/sge_pkg.sv
// Shared types and constants for the Sobel edge stream block.
`default_nettype none
package sge_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;
  localparam int ABS_W   = 10;
  localparam int SUM_W   = 22;
  localparam int ROOT_W  = 11;
  localparam int REM_W   = 12;
  localparam int ITER_W  = 4;

  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MAG_THRESH   = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [CFG_W-1:0] RST_MAG_THRESH   = 11'd100;

  typedef struct packed {
    logic capture;
    logic rd;
    logic shift;
    logic calc;
    logic sqx;
    logic sqy;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic item_ok;
    logic emit;
    logic sqrt_done;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

>>> sv/sge_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`default_nettype none
module sge_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [sge_pkg::SUM_W-1:0] radicand,
  output logic      [sge_pkg::ROOT_W-1:0] root,
  output logic                           rem_nz,
  output logic                           done
);
  logic [sge_pkg::SUM_W-1:0]  rad;
  logic [sge_pkg::REM_W-1:0]  rem;
  logic [sge_pkg::ITER_W-1:0] cnt;
  logic [sge_pkg::REM_W+1:0]  rem_sh;
  logic [sge_pkg::REM_W+1:0]  trial;
  logic                       ge;

  assign rem_sh = {rem, rad[sge_pkg::SUM_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= sge_pkg::ITER_W'(sge_pkg::ROOT_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= rad << 2;
      rem  <= ge ? sge_pkg::REM_W'(rem_sh - trial) : sge_pkg::REM_W'(rem_sh);
      root <= {root[sge_pkg::ROOT_W-2:0], ge};
    end
  end

  assign rem_nz = rem != '0;
  assign done   = cnt == '0;
endmodule
`default_nettype wire

>>> sv/sge_dp.sv
// Datapath: line stores, window, counters, gradients, magnitude and output register.
`default_nettype none
module sge_dp #(
  parameter int MAX_WIDTH  = sge_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sge_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sge_pkg::cmd_t              cmd,
  output sge_pkg::sts_t                   sts,
  input  wire logic                       cfg_we,
  input  wire logic [sge_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [sge_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       func,
  input  wire logic [sge_pkg::PIX_W-1:0]  pixel,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [sge_pkg::GRAD_W-1:0] grad_x,
  output logic signed [sge_pkg::GRAD_W-1:0] grad_y,
  output logic [sge_pkg::ROOT_W-1:0]      magnitude,
  output logic                            edge_res,
  output logic                            last
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int DW0  = (sge_pkg::CFG_W > CW + 1) ? sge_pkg::CFG_W : CW + 1;
  localparam int DIMW = (DW0 > RW) ? DW0 : RW;
  localparam int PW   = sge_pkg::PIX_W;

  logic [sge_pkg::CFG_W-1:0] frame_width, frame_height, mag_threshold;
  logic [DIMW-1:0] w, h;

  logic [PW-1:0] upper [MAX_WIDTH];
  logic [PW-1:0] lower [MAX_WIDTH];
  logic [PW-1:0] top_q, mid_q, p_q;
  logic [PW-1:0] win [3][3];

  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic          tail, emit_q;
  logic [CW:0]   col_inc, ocol_inc;
  logic [RW-1:0] row_inc, orow_inc;
  logic          is_first_col, is_last_col, is_first_row, is_last_row, last_c, last_q;

  logic [PW-1:0] px [3][3];
  logic [1:0]    src_l, src_r;
  logic [PW+1:0] sum_r, sum_l, sum_b, sum_t;
  logic signed [sge_pkg::GRAD_W-1:0] gx, gy, gx_q, gy_q;
  logic [sge_pkg::ABS_W-1:0] ax_q, ay_q, mop;
  logic [2*sge_pkg::ABS_W-1:0] prod;
  logic [sge_pkg::SUM_W-1:0] acc;
  logic [sge_pkg::ROOT_W-1:0] root;
  logic rem_nz, sqrt_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= sge_pkg::RST_FRAME_WIDTH;
      frame_height  <= sge_pkg::RST_FRAME_HEIGHT;
      mag_threshold <= sge_pkg::RST_MAG_THRESH;
    end else if (cfg_we) begin
      case (cfg_index)
        sge_pkg::REG_FRAME_WIDTH:  frame_width   <= cfg_data;
        sge_pkg::REG_FRAME_HEIGHT: frame_height  <= cfg_data;
        sge_pkg::REG_MAG_THRESH:   mag_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w = DIMW'(frame_width);
    if (w == '0) w = DIMW'(1);
    else if (w > DIMW'(MAX_WIDTH)) w = DIMW'(MAX_WIDTH);
    h = DIMW'(frame_height);
    if (h == '0) h = DIMW'(1);
    else if (h > DIMW'(MAX_HEIGHT)) h = DIMW'(MAX_HEIGHT);
  end

  // line stores
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      top_q <= upper[in_col];
      mid_q <= lower[in_col];
    end
    if (cmd.shift) begin
      upper[in_col] <= mid_q;
      lower[in_col] <= p_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) p_q <= func ? '0 : pixel;
  end

  assign col_inc  = {1'b0, in_col} + 1'b1;
  assign row_inc  = in_row + 1'b1;
  assign ocol_inc = {1'b0, out_col} + 1'b1;
  assign orow_inc = out_row + 1'b1;
  assign is_first_col = out_col == '0;
  assign is_first_row = out_row == '0;
  assign is_last_col  = DIMW'(ocol_inc) >= w;
  assign is_last_row  = DIMW'(orow_inc) >= h;
  assign last_c       = is_last_col && is_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      tail    <= 1'b0;
      emit_q  <= 1'b0;
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++) win[c][r] <= '0;
    end else begin
      if (cmd.shift) begin
        emit_q <= (in_row >= RW'(2)) || (in_row == RW'(1) && in_col != '0);
        win[0] <= win[1];
        win[1] <= win[2];
        win[2][0] <= top_q;
        win[2][1] <= mid_q;
        win[2][2] <= p_q;
        if (DIMW'(col_inc) >= w) begin
          in_col <= '0;
          in_row <= row_inc;
          if (!tail && DIMW'(row_inc) >= h) tail <= 1'b1;
        end else begin
          in_col <= col_inc[CW-1:0];
          if (!tail && DIMW'(in_row) >= h) tail <= 1'b1;
        end
      end
      if (cmd.calc && emit_q) begin
        if (last_c) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
          tail    <= 1'b0;
        end else if (is_last_col) begin
          out_col <= '0;
          out_row <= orow_inc;
        end else begin
          out_col <= ocol_inc[CW-1:0];
        end
      end
    end
  end

  // border replication
  always_comb begin
    src_l = is_first_col ? 2'd1 : 2'd0;
    src_r = is_last_col ? 2'd1 : 2'd2;
    for (int r = 0; r < 3; r++) begin
      px[0][r] = win[src_l][r];
      px[1][r] = win[1][r];
      px[2][r] = win[src_r][r];
    end
    for (int c = 0; c < 3; c++) begin
      if (is_first_row) px[c][0] = px[c][1];
      if (is_last_row)  px[c][2] = px[c][1];
    end
  end

  assign sum_r = (PW+2)'(px[2][0]) + {1'b0, px[2][1], 1'b0} + (PW+2)'(px[2][2]);
  assign sum_l = (PW+2)'(px[0][0]) + {1'b0, px[0][1], 1'b0} + (PW+2)'(px[0][2]);
  assign sum_b = (PW+2)'(px[0][2]) + {1'b0, px[1][2], 1'b0} + (PW+2)'(px[2][2]);
  assign sum_t = (PW+2)'(px[0][0]) + {1'b0, px[1][0], 1'b0} + (PW+2)'(px[2][0]);
  assign gx = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
  assign gy = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      gx_q   <= gx;
      gy_q   <= gy;
      ax_q   <= gx[sge_pkg::GRAD_W-1] ? sge_pkg::ABS_W'(-gx) : sge_pkg::ABS_W'(gx);
      ay_q   <= gy[sge_pkg::GRAD_W-1] ? sge_pkg::ABS_W'(-gy) : sge_pkg::ABS_W'(gy);
      last_q <= last_c;
    end
  end

  // one shared multiplier: x term then y term
  assign mop  = cmd.sqy ? ay_q : ax_q;
  assign prod = mop * mop;

  always_ff @(posedge clk) begin
    if (cmd.sqx) acc <= sge_pkg::SUM_W'(prod);
    else if (cmd.sqy) acc <= acc + sge_pkg::SUM_W'(prod);
  end

  sge_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (acc),
    .root     (root),
    .rem_nz   (rem_nz),
    .done     (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // s > t^2 exactly when root > t, or root == t with a nonzero remainder
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      grad_x    <= gx_q;
      grad_y    <= gy_q;
      magnitude <= root;
      edge_res  <= (root > mag_threshold) || (root == mag_threshold && rem_nz);
      last      <= last_q;
    end
  end

  assign sts.item_ok   = func == tail;
  assign sts.emit      = emit_q;
  assign sts.sqrt_done = sqrt_done;
  assign sts.out_free  = !out_valid || out_ready;
endmodule
`default_nettype wire

>>> sv/sge_ctrl.sv
// Controller: sequences one item through read, shift, gradient, square, root and load.
`default_nettype none
module sge_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sge_pkg::sts_t sts,
  output sge_pkg::cmd_t      cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_SH   = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_SQX  = 4'd4;
  localparam logic [3:0] S_SQY  = 4'd5;
  localparam logic [3:0] S_SQS  = 4'd6;
  localparam logic [3:0] S_SQW  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && sts.item_ok) begin
          cmd.capture = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_SH;
      end
      S_SH: begin
        cmd.shift = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_next = sts.emit ? S_SQX : S_IDLE;
      end
      S_SQX: begin
        cmd.sqx = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sqy = 1'b1;
        state_next = S_SQS;
      end
      S_SQS: begin
        cmd.sqrt_start = 1'b1;
        state_next = S_SQW;
      end
      S_SQW: begin
        if (sts.sqrt_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = state == S_IDLE;

  a_sqrt_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |=> !sts.sqrt_done) else $error("root unit not busy after start");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free) else $error("output register overwritten");
  a_no_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && !sts.emit) |=> in_ready) else $error("silent item did not return");
endmodule
`default_nettype wire

>>> sv/sobel_gradient_edge_stream.sv
// Top level of the streaming 3x3 Sobel edge detector.
//
// channel | signals                                       | dir
// in      | in_valid in_ready func pixel                  | in
// out     | out_valid out_ready grad_x grad_y magnitude   | out
//         |   edge_res last                               |
// cfg     | cfg_we cfg_index cfg_data                     | in
//
// A pixel or drain transfer that yields a result goes through line store read, shift and
// gradients, the two squares and root start, the two-bits-per-cycle root and its done check,
// and the load into the output register; ready returns after the load, so such an item is
// finished before the next is taken. Transfers with no result return to idle after the
// gradient step; dropped transfers leave the controller idle.
// Reset is synchronous; no clearing pass, line stores are not reset.
// A stalled output holds only the final load; the next item is not taken until that load is done.
`default_nettype none
module sobel_gradient_edge_stream #(
  parameter int MAX_WIDTH  = sge_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sge_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [sge_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [sge_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         func,
  input  wire logic [sge_pkg::PIX_W-1:0]    pixel,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [sge_pkg::GRAD_W-1:0] grad_x,
  output logic signed [sge_pkg::GRAD_W-1:0] grad_y,
  output logic [sge_pkg::ROOT_W-1:0]        magnitude,
  output logic                              edge_res,
  output logic                              last
);
  sge_pkg::cmd_t cmd;
  sge_pkg::sts_t sts;

  sge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sge_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (func),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .magnitude (magnitude),
    .edge_res  (edge_res),
    .last      (last)
  );
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the streaming Sobel edge detector.
`timescale 1ns / 1ps
module tb_top;
  typedef struct packed {
    logic                      drain;
    logic [sge_pkg::PIX_W-1:0] pix;
  } px_item_t;

  typedef struct packed {
    logic signed [sge_pkg::GRAD_W-1:0] gx;
    logic signed [sge_pkg::GRAD_W-1:0] gy;
    logic [sge_pkg::ROOT_W-1:0]        mag;
    logic                              edge_f;
    logic                              last_f;
  } sobel_result_t;

  localparam int MAXW = sge_pkg::DEF_MAX_WIDTH;
  localparam int MAXH = sge_pkg::DEF_MAX_HEIGHT;
  localparam int SETTLE_CYC = 40;
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [sge_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [sge_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [sge_pkg::PIX_W-1:0] pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [sge_pkg::GRAD_W-1:0] grad_x, grad_y;
  logic [sge_pkg::ROOT_W-1:0] magnitude;
  logic edge_res, last;

  sobel_gradient_edge_stream dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready), .grad_x(grad_x), .grad_y(grad_y),
    .magnitude(magnitude), .edge_res(edge_res), .last(last)
  );

  always #6 clk = ~clk;

  // predictor state
  int unsigned cfg_width = 32'(sge_pkg::RST_FRAME_WIDTH);
  int unsigned cfg_height = 32'(sge_pkg::RST_FRAME_HEIGHT);
  int unsigned cfg_thresh = 32'(sge_pkg::RST_MAG_THRESH);
  logic [7:0] row_upper [MAXW];
  logic [7:0] row_lower [MAXW];
  logic [7:0] win [9];
  int unsigned in_col, in_row, out_col, out_row;
  bit draining;

  px_item_t pixel_q[$];
  sobel_result_t gradient_q[$];
  int err_cnt = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int items_sent = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned floor_root(int unsigned s);
    int unsigned r;
    r = 0;
    for (int b = 11; b >= 0; b--)
      if ((r | (1 << b)) * (r | (1 << b)) <= s) r = r | (1 << b);
    return r;
  endfunction

  task automatic sobel_predict(input logic drain, input logic [7:0] p_in);
    int unsigned w, h, idx, src, ssum;
    int px [3][3];
    int gx, gy;
    bit emit;
    logic [7:0] top, mid, p;
    sobel_result_t r;
    if (drain == FUNC_PIXEL && draining) return;
    if (drain == FUNC_DRAIN && !draining) return;
    p = (drain == FUNC_DRAIN) ? 8'd0 : p_in;
    w = clamp_dim(cfg_width, MAXW);
    h = clamp_dim(cfg_height, MAXH);
    idx = (in_col < MAXW) ? in_col : MAXW - 1;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    top = row_upper[idx];
    mid = row_lower[idx];
    row_upper[idx] = mid;
    row_lower[idx] = p;
    for (int k = 0; k < 6; k++) win[k] = win[k+3];
    win[6] = top;
    win[7] = mid;
    win[8] = p;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!draining && in_row >= h) draining = 1;
    if (!emit) return;
    for (int c = 0; c < 3; c++) begin
      src = c;
      if (c == 0 && out_col == 0) src = 1;
      if (c == 2 && out_col + 1 >= w) src = 1;
      for (int k = 0; k < 3; k++) px[c][k] = int'(win[src*3 + k]);
      if (out_row == 0) px[c][0] = px[c][1];
      if (out_row + 1 >= h) px[c][2] = px[c][1];
    end
    gx = (px[2][0] + 2*px[2][1] + px[2][2]) - (px[0][0] + 2*px[0][1] + px[0][2]);
    gy = (px[0][2] + 2*px[1][2] + px[2][2]) - (px[0][0] + 2*px[1][0] + px[2][0]);
    ssum = gx*gx + gy*gy;
    r.gx = gx[sge_pkg::GRAD_W-1:0];
    r.gy = gy[sge_pkg::GRAD_W-1:0];
    r.mag = sge_pkg::ROOT_W'(floor_root(ssum));
    r.edge_f = ssum > cfg_thresh * cfg_thresh;
    r.last_f = (out_row + 1 >= h) && (out_col + 1 >= w);
    gradient_q = {gradient_q, r};
    if (r.last_f) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; draining = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  px_item_t nxt;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) sobel_predict(func, pixel);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          in_valid <= 1'b1;
          func <= nxt.drain;
          pixel <= nxt.pix;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode re-chosen at random periodically, long hold-off periodically
  int unsigned rx_cyc = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (rx_cyc % 8000 >= 1500 && rx_cyc % 8000 < 1900)
        out_ready <= 1'b0;
      else case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_cyc % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic flag_error(input string msg);
    $display("ERROR t=%0t result %0d: %s", $realtime, results_seen, msg);
    err_cnt++;
  endtask

  sobel_result_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (gradient_q.size() == 0) begin
        flag_error("result with no expectation");
      end else begin
        want = gradient_q.pop_front();
        if (grad_x !== want.gx) flag_error($sformatf("grad_x %0d exp %0d", grad_x, want.gx));
        if (grad_y !== want.gy) flag_error($sformatf("grad_y %0d exp %0d", grad_y, want.gy));
        if (magnitude !== want.mag)
          flag_error($sformatf("magnitude %0d exp %0d", magnitude, want.mag));
        if (edge_res !== want.edge_f)
          flag_error($sformatf("edge_res %0b exp %0b", edge_res, want.edge_f));
        if (last !== want.last_f) flag_error($sformatf("last %0b exp %0b", last, want.last_f));
        if (want.last_f) frames_seen++;
      end
      results_seen++;
    end
  end

  task automatic push_item(input logic drain, input logic [7:0] p);
    px_item_t it;
    it.drain = drain;
    it.pix = p;
    pixel_q = {pixel_q, it};
    items_sent++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || gradient_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sge_pkg::CIDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[sge_pkg::CFG_W-1:0];
    case (idx)
      sge_pkg::REG_FRAME_WIDTH:  cfg_width = val & 32'h7FF;
      sge_pkg::REG_FRAME_HEIGHT: cfg_height = val & 32'h7FF;
      sge_pkg::REG_MAG_THRESH:   cfg_thresh = val & 32'h7FF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned th);
    cfg_write(sge_pkg::REG_FRAME_WIDTH, w);
    cfg_write(sge_pkg::REG_FRAME_HEIGHT, h);
    cfg_write(sge_pkg::REG_MAG_THRESH, th);
  endtask

  // pattern: 0 random, 1 random black/white, 2 vertical stripes, 3 horizontal stripes
  task automatic gen_frame(input int unsigned pattern, input bit noise);
    int unsigned w, h;
    logic [7:0] v;
    w = clamp_dim(cfg_width, MAXW);
    h = clamp_dim(cfg_height, MAXH);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (noise && $urandom_range(0, 15) == 0) push_item(FUNC_DRAIN, 8'($urandom));
        case (pattern)
          0: v = 8'($urandom);
          1: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          2: v = (c % 2) ? 8'hFF : 8'h00;
          default: v = (r % 2) ? 8'hFF : 8'h00;
        endcase
        push_item(FUNC_PIXEL, v);
      end
    for (int d = 0; d <= w; d++) begin
      if (noise && $urandom_range(0, 7) == 0) push_item(FUNC_PIXEL, 8'($urandom));
      push_item(FUNC_DRAIN, 8'($urandom));
    end
  endtask

  int unsigned rw, rh, rt, sel;
  initial begin
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; draining = 0;
    foreach (win[k]) win[k] = '0;
    foreach (row_upper[k]) begin
      row_upper[k] = '0;
      row_lower[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // zero dimensions clamp to a single pixel; stray drain is ignored
    set_frame(0, 0, 0);
    push_item(FUNC_DRAIN, 8'h5A);
    push_item(FUNC_PIXEL, 8'hFF);
    push_item(FUNC_DRAIN, 8'h00);
    push_item(FUNC_PIXEL, 8'h12);
    push_item(FUNC_DRAIN, 8'h00);
    wait_idle();
    set_frame(3, 3, 1443);
    gen_frame(2, 1);
    wait_idle();
    // threshold beyond the magnitude range
    set_frame(3, 2, 2047);
    gen_frame(3, 0);
    wait_idle();
    // width change in the middle of a frame
    set_frame(4, 3, 50);
    for (int k = 0; k < 8; k++) push_item(FUNC_PIXEL, 8'($urandom));
    wait_idle();
    cfg_write(sge_pkg::REG_FRAME_WIDTH, 2);
    for (int k = 0; k < 12; k++) push_item(FUNC_PIXEL, 8'($urandom));
    for (int k = 0; k < 12; k++) push_item(FUNC_DRAIN, 8'($urandom));
    wait_idle();
    // oversized dimensions, then a shrink that wraps the partial row
    set_frame(2047, 2047, 300);
    for (int k = 0; k < 30; k++) push_item(FUNC_PIXEL, 8'($urandom));
    wait_idle();
    set_frame(3, 1, 300);
    push_item(FUNC_PIXEL, 8'($urandom));
    for (int k = 0; k < 8; k++) push_item(FUNC_DRAIN, 8'($urandom));
    wait_idle();

    while (items_sent < 850) begin
      sel = $urandom_range(0, 19);
      rw = (sel < 14) ? $urandom_range(1, 8) : (sel < 19) ? $urandom_range(9, 40) : 0;
      sel = $urandom_range(0, 19);
      rh = (sel < 18) ? $urandom_range(1, 6) : 0;
      sel = $urandom_range(0, 9);
      rt = (sel < 6) ? $urandom_range(0, 400) : (sel == 6) ? 0 : (sel == 7) ? 1443 :
           (sel == 8) ? $urandom_range(401, 1443) : $urandom_range(1444, 2047);
      set_frame(rw, rh, rt);
      repeat ($urandom_range(1, 3)) gen_frame($urandom_range(0, 3), 1'($urandom_range(0, 1)));
      wait_idle();
    end

    $display("Covered %0d frames and %0d checked results over several frame shapes,",
             frames_seen, results_seen);
    $display("thresholds, stray drains, dropped pixels and output back-pressure.");
    if (err_cnt == 0 && gradient_q.size() == 0) begin
      $display("PASS sobel_gradient_edge_stream");
    end else begin
      $display("FAIL sobel_gradient_edge_stream");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", gradient_q.size());
    $display("FAIL sobel_gradient_edge_stream");
    $finish;
  end
endmodule
